FILE: rtl/beq_pkg.sv
// Shared constants, register indexes and controller/datapath types for the equalizer bank.
`default_nettype none

package beq_pkg;

    // Default sizes, handed down from the top level.
    localparam int DEF_MAX_BANDS      = 64;
    localparam int DEF_MAX_CHANNELS   = 8;
    localparam int DEF_COEF_FRAC_BITS = 15;

    // Field widths fixed by the item format.
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int BAND_IDX_W = 6;
    localparam int CH_OUT_W   = 3;
    localparam int BAND_CNT_W = 7;
    localparam int CHAN_CNT_W = 4;

    // Widest command fields over the legal parameter range.
    localparam int CH_IDX_W        = 4;
    localparam int HIST_ADDR_MAX_W = 10;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BANDS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;

    localparam logic [BAND_CNT_W-1:0] ACTIVE_BANDS_RST  = 7'd15;
    localparam logic [CHAN_CNT_W-1:0] CHANNEL_COUNT_RST = 4'd1;

    // Item kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic                       start;     // sample taken: latch x, clear accumulator
        logic                       issue;     // read coefficients and history of one band
        logic [BAND_IDX_W-1:0]      band;
        logic [CH_IDX_W-1:0]        ch;
        logic                       clear;     // clearing pass write
        logic [HIST_ADDR_MAX_W-1:0] clr_addr;
        logic                       coef_wr;   // coefficient item taken
        logic                       finish;    // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic busy;       // band pipeline holds work
        logic out_free;   // output register can take a result this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/beq_if.sv
// Handshake channel interfaces: input items, result items and configuration writes.
`default_nettype none

interface beq_in_if import beq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [BAND_IDX_W-1:0]      band_index;
    logic signed [COEF_W-1:0]   coef_alpha;
    logic signed [COEF_W-1:0]   coef_beta;
    logic signed [COEF_W-1:0]   coef_gamma;
    logic                       end_mark;

    modport source (output valid, kind, sample, band_index, coef_alpha, coef_beta,
                    coef_gamma, end_mark, input ready);
    modport sink   (input valid, kind, sample, band_index, coef_alpha, coef_beta,
                    coef_gamma, end_mark, output ready);
endinterface

interface beq_out_if import beq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic [CH_OUT_W-1:0]        channel_index;
    logic                       end_out;

    modport source (output valid, filtered_sample, channel_index, end_out, input ready);
    modport sink   (input valid, filtered_sample, channel_index, end_out, output ready);
endinterface

interface beq_cfg_if import beq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/biquad_bandpass_equalizer_bank_core.sv
// Top level of the parallel bandpass biquad equalizer bank.
//
//  channel   dir  handshake      carries
//  i_in      in   valid/ready    kind, sample, band_index, coef_alpha/beta/gamma, end_mark
//  o_out     out  valid/ready    filtered_sample, channel_index, end_out
//  i_cfg     in   valid/ready    index (0 active bands, 1 channel count), data
//
//  Sequencing: a coefficient item is stored straight from idle; an audio sample runs its N active
//  bands one band per cycle through the single section pipeline (memory read, multiply,
//  combine), then the pipeline drains and the final mix is taken.
//  Reset: synchronous, active low; afterwards the history memory is cleared one entry per
//  cycle, all MAX_CHANNELS * MAX_BANDS entries (512 by default), with i_in held not ready.
//  Stalls: a finished result waits in the output register while the next item is taken;
//  only the final step of the following sample waits for o_out to drain.
//  Config writes are always ready and are expected only while the block is idle.
`default_nettype none

module biquad_bandpass_equalizer_bank_core import beq_pkg::*; #(
    parameter int MAX_BANDS      = DEF_MAX_BANDS,
    parameter int MAX_CHANNELS   = DEF_MAX_CHANNELS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    beq_in_if.sink    i_in,
    beq_out_if.source o_out,
    beq_cfg_if.sink   i_cfg
);

    // Command and status between sequencer and datapath.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Controller: owns the config registers, the channel counter, the band sequence
    // and the post-reset clearing sweep.
    beq_ctrl #(
        .MAX_BANDS    (MAX_BANDS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Datapath: coefficient store, per-channel band history, section pipeline,
    // accumulator and output register. Payload comes straight from the input channel;
    // the controller decides when it is taken.
    beq_datapath #(
        .MAX_BANDS      (MAX_BANDS),
        .MAX_CHANNELS   (MAX_CHANNELS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_sample     (i_in.sample),
        .i_band_index (i_in.band_index),
        .i_coef_alpha (i_in.coef_alpha),
        .i_coef_beta  (i_in.coef_beta),
        .i_coef_gamma (i_in.coef_gamma),
        .i_end_mark   (i_in.end_mark),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

FILE: rtl/beq_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none

module beq_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/beq_ctrl.sv
// Controller: configuration registers, channel rotation, band sequencing and history clearing.
`default_nettype none

module beq_ctrl import beq_pkg::*; #(
    parameter int MAX_BANDS    = DEF_MAX_BANDS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    beq_in_if.sink       i_in,
    beq_cfg_if.sink      i_cfg,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd      o_cmd
);

    localparam int BC_W  = $clog2(MAX_BANDS + 1);
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHN_W = CH_W + 1;
    localparam int DEPTH = MAX_CHANNELS * MAX_BANDS;
    localparam int HA_W  = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state                r_state, n_state;
    logic [HA_W-1:0]       r_clr, n_clr;
    logic [BC_W-1:0]       r_band, n_band;
    logic [CH_W-1:0]       r_chan, n_chan;
    logic [CH_W-1:0]       r_cur_ch, n_cur_ch;
    logic [BAND_CNT_W-1:0] r_band_cfg;
    logic [CHAN_CNT_W-1:0] r_chan_cfg;

    logic [BC_W-1:0]       w_bands;
    logic [CHAN_CNT_W:0]   w_chan_lim;
    logic [CHN_W-1:0]      w_chans;
    logic [CH_W-1:0]       w_ch;
    logic [CH_W-1:0]       w_ch_next;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);

    // Effective band and channel counts.
    assign w_bands = (r_band_cfg > BAND_CNT_W'(MAX_BANDS)) ? BC_W'(MAX_BANDS)
                                                           : BC_W'(r_band_cfg);
    assign w_chan_lim = (r_chan_cfg == '0) ? (CHAN_CNT_W+1)'(1)
                                           : (CHAN_CNT_W+1)'(r_chan_cfg);
    assign w_chans = (w_chan_lim > (CHAN_CNT_W+1)'(MAX_CHANNELS)) ? CHN_W'(MAX_CHANNELS)
                                                                  : CHN_W'(w_chan_lim);
    assign w_ch      = (CHN_W'(r_chan) < w_chans) ? r_chan : '0;
    assign w_ch_next = ((CHN_W'(w_ch) + 1'b1) >= w_chans) ? '0 : CH_W'(w_ch + 1'b1);

    always_comb begin
        n_state        = r_state;
        n_clr          = r_clr;
        n_band         = r_band;
        n_chan         = r_chan;
        n_cur_ch       = r_cur_ch;
        o_cmd          = '0;
        o_cmd.band     = BAND_IDX_W'(r_band);
        o_cmd.ch       = CH_IDX_W'(r_cur_ch);
        o_cmd.clr_addr = HIST_ADDR_MAX_W'(r_clr);
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (r_clr == HA_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.kind == KIND_COEF) begin
                        o_cmd.coef_wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        o_cmd.ch    = CH_IDX_W'(w_ch);
                        n_cur_ch    = w_ch;
                        n_chan      = w_ch_next;
                        n_band      = '0;
                        n_state     = (w_bands == '0) ? ST_DRAIN : ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                n_band      = r_band + 1'b1;
                if (BC_W'(r_band + 1'b1) == w_bands) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_band     <= '0;
            r_chan     <= '0;
            r_cur_ch   <= '0;
            r_band_cfg <= ACTIVE_BANDS_RST;
            r_chan_cfg <= CHANNEL_COUNT_RST;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_band   <= n_band;
            r_chan   <= n_chan;
            r_cur_ch <= n_cur_ch;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_ACTIVE_BANDS) begin
                    r_band_cfg <= i_cfg.data[BAND_CNT_W-1:0];
                end else if (i_cfg.index == CFG_CHANNEL_COUNT) begin
                    r_chan_cfg <= i_cfg.data[CHAN_CNT_W-1:0];
                end
            end
        end
    end

    // A new sample never starts on top of an unfinished band pipeline.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> !i_stat.busy)
        else $error("sample started while band pipeline busy");

    // Every issued band shows up as pipeline work in the next cycle.
    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |=> i_stat.busy)
        else $error("issued band not tracked by datapath");

    // The clearing pass and band work never overlap.
    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |-> !(o_cmd.issue || o_cmd.start || o_cmd.coef_wr))
        else $error("clearing pass overlaps other work");

endmodule

`default_nettype wire

FILE: rtl/beq_datapath.sv
// Datapath: coefficient and history memories, band section pipeline, accumulator, output register.
`default_nettype none

module beq_datapath import beq_pkg::*; #(
    parameter int MAX_BANDS      = DEF_MAX_BANDS,
    parameter int MAX_CHANNELS   = DEF_MAX_CHANNELS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_stat                        o_stat,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic [BAND_IDX_W-1:0]      i_band_index,
    input  wire logic signed [COEF_W-1:0]   i_coef_alpha,
    input  wire logic signed [COEF_W-1:0]   i_coef_beta,
    input  wire logic signed [COEF_W-1:0]   i_coef_gamma,
    input  wire logic                       i_end_mark,
    beq_out_if.source                       o_out
);

    localparam int BA_W    = $clog2(MAX_BANDS);
    localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DEPTH   = MAX_CHANNELS * MAX_BANDS;
    localparam int HA_W    = $clog2(DEPTH);
    localparam int CE_W    = 3 * COEF_W;
    localparam int HE_W    = 4 * SAMPLE_W;
    localparam int P_W     = COEF_W + SAMPLE_W + 1;
    localparam int SUM_W   = P_W + 2;
    localparam int ACC_W   = SAMPLE_W + BA_W + 1;
    localparam int DRY_SH  = 2;                    // dry path weight of one quarter
    localparam int T_W     = ACC_W + DRY_SH + 1;
    localparam logic signed [P_W-1:0] P_RND = P_W'((64'sd1 <<< COEF_FRAC_BITS) - 64'sd1);
    localparam logic signed [T_W-1:0] T_RND = T_W'((1 << DRY_SH) - 1);

    function automatic logic signed [P_W-1:0] trunc_scale(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] v;
        v = p[P_W-1] ? (p + P_RND) : p;
        return v >>> COEF_FRAC_BITS;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SUM_W'(SAMPLE_MAX)) begin
            r = SAMPLE_MAX;
        end else if (v < SUM_W'(SAMPLE_MIN)) begin
            r = SAMPLE_MIN;
        end else begin
            r = SAMPLE_W'(v);
        end
        return r;
    endfunction

    // Sample context
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_end;
    logic [CH_OUT_W-1:0]        r_ch_out;

    // Coefficient store with per-band valid bits
    logic [MAX_BANDS-1:0]       r_coef_vld;
    logic                       w_coef_we;
    logic [CE_W-1:0]            w_coef_q;
    logic [HE_W-1:0]            w_hist_q;
    logic [HA_W-1:0]            w_hist_raddr;

    // Pipeline
    logic                       r_s1_vld, r_s1_cvld;
    logic [HA_W-1:0]            r_s1_addr;
    logic signed [COEF_W-1:0]   w_alpha, w_beta, w_gamma;
    logic signed [SAMPLE_W-1:0] w_x1, w_x2, w_y1, w_y2;
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [P_W-1:0]      w_pa, w_pg, w_pb;

    logic                       r_s2_vld;
    logic [HA_W-1:0]            r_s2_addr;
    logic signed [P_W-1:0]      r_pa, r_pg, r_pb;
    logic signed [SAMPLE_W-1:0] r_s2_x1, r_s2_y1;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [SAMPLE_W-1:0] w_y;

    logic                       r_y_vld;
    logic signed [SAMPLE_W-1:0] r_y;
    logic signed [ACC_W-1:0]    r_acc;

    logic                       w_hist_we;
    logic [HA_W-1:0]            w_hist_waddr;
    logic [HE_W-1:0]            w_hist_wdata;

    logic signed [T_W-1:0]      w_total4, w_total;
    logic signed [SAMPLE_W-1:0] w_result;

    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [CH_OUT_W-1:0]        r_out_ch;
    logic                       r_out_end;

    assign w_coef_we = i_cmd.coef_wr &&
                       ({1'b0, i_band_index} < (BAND_IDX_W+1)'(MAX_BANDS));

    beq_ram #(.WIDTH(CE_W), .DEPTH(MAX_BANDS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (i_band_index[BA_W-1:0]),
        .i_wdata ({i_coef_alpha, i_coef_beta, i_coef_gamma}),
        .i_raddr (i_cmd.band[BA_W-1:0]),
        .o_rdata (w_coef_q)
    );

    assign w_hist_raddr = HA_W'(HA_W'(i_cmd.ch[CH_W-1:0]) * HA_W'(MAX_BANDS))
                        + HA_W'(i_cmd.band[BA_W-1:0]);

    beq_ram #(.WIDTH(HE_W), .DEPTH(DEPTH)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_raddr (w_hist_raddr),
        .o_rdata (w_hist_q)
    );

    // Stage 1: unwritten bands read as zero coefficients
    assign w_alpha = r_s1_cvld ? w_coef_q[CE_W-1 -: COEF_W]            : '0;
    assign w_beta  = r_s1_cvld ? w_coef_q[CE_W-COEF_W-1 -: COEF_W]     : '0;
    assign w_gamma = r_s1_cvld ? w_coef_q[COEF_W-1:0]                  : '0;
    assign w_x1    = w_hist_q[HE_W-1 -: SAMPLE_W];
    assign w_x2    = w_hist_q[HE_W-SAMPLE_W-1 -: SAMPLE_W];
    assign w_y1    = w_hist_q[2*SAMPLE_W-1 -: SAMPLE_W];
    assign w_y2    = w_hist_q[SAMPLE_W-1:0];
    assign w_diff  = (SAMPLE_W+1)'(r_x) - (SAMPLE_W+1)'(w_x2);
    assign w_pa    = w_alpha * w_diff;
    assign w_pg    = w_gamma * w_y1;
    assign w_pb    = w_beta * w_y2;

    // Stage 2: scale, combine, saturate, write history back
    assign w_sum = SUM_W'(trunc_scale(r_pa)) + SUM_W'(trunc_scale(r_pg))
                 - SUM_W'(trunc_scale(r_pb));
    assign w_y   = sat16(w_sum);

    assign w_hist_we    = i_cmd.clear || r_s2_vld;
    assign w_hist_waddr = i_cmd.clear ? i_cmd.clr_addr[HA_W-1:0] : r_s2_addr;
    assign w_hist_wdata = i_cmd.clear ? '0 : {r_x, r_s2_x1, w_y, r_s2_y1};

    // Final mix: bands plus a quarter of the dry sample, truncated toward zero
    assign w_total4 = (T_W'(r_acc) <<< DRY_SH) + T_W'(r_x);
    assign w_total  = (w_total4[T_W-1] ? (w_total4 + T_RND) : w_total4) >>> DRY_SH;
    assign w_result = sat16(SUM_W'(w_total));

    assign o_stat.busy     = r_s1_vld || r_s2_vld || r_y_vld;
    assign o_stat.out_free = !r_out_vld || o_out.ready;

    assign o_out.valid           = r_out_vld;
    assign o_out.filtered_sample = r_out_sample;
    assign o_out.channel_index   = r_out_ch;
    assign o_out.end_out         = r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_y_vld    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_coef_we) begin
                r_coef_vld[i_band_index[BA_W-1:0]] <= 1'b1;
            end
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
            r_y_vld  <= r_s2_vld;
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x      <= i_sample;
            r_end    <= i_end_mark;
            r_ch_out <= CH_OUT_W'(i_cmd.ch);
        end
        r_s1_cvld <= r_coef_vld[i_cmd.band[BA_W-1:0]];
        r_s1_addr <= w_hist_raddr;
        r_s2_addr <= r_s1_addr;
        r_pa      <= w_pa;
        r_pg      <= w_pg;
        r_pb      <= w_pb;
        r_s2_x1   <= w_x1;
        r_s2_y1   <= w_y1;
        r_y       <= w_y;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_y_vld) begin
            r_acc <= r_acc + ACC_W'(r_y);
        end
        if (i_cmd.finish) begin
            r_out_sample <= w_result;
            r_out_ch     <= r_ch_out;
            r_out_end    <= r_end;
        end
    end

    // A result is only formed once every band has landed in the accumulator.
    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !o_stat.busy)
        else $error("result formed before band pipeline drained");

    // A held result is never overwritten.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_vld || o_out.ready))
        else $error("output register overwritten");

    // History write-back never collides with the clearing pass.
    a_wb_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clear && r_s2_vld))
        else $error("history write-back during clearing pass");

endmodule

`default_nettype wire
